// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising clk edge outside reset
`define YRGB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define YRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define YRGB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define YRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/yrgb_pkg.sv =====
// types, constants and helpers for the yuyv to scaled rgb converter
`default_nettype none

package yrgb_pkg;

  localparam int unsigned PIX_W = 8;
  // signed q16 sums stay below 2^25 in magnitude
  localparam int unsigned SUM_W = 26;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CHR_W = PIX_W + 1;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned STAGES = 5;

  localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] OUT_MAX = 8'd219;

  // unsigned q16 coefficients, held signed for the multipliers
  localparam logic signed [COEF_W-1:0] COEF_R_V = 18'sd89831;
  localparam logic signed [COEF_W-1:0] COEF_G_V = 18'sd45744;
  localparam logic signed [COEF_W-1:0] COEF_G_U = 18'sd22127;
  localparam logic signed [COEF_W-1:0] COEF_B_U = 18'sd113538;

  localparam logic [2*PIX_W-1:0] SCALE_MUL = 16'd220;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [CHR_W-1:0] chroma_t;
  typedef logic [PIX_W-1:0] pix_t;

  // chroma byte minus mid level
  function automatic chroma_t center(input pix_t c);
    return chroma_t'({1'b0, c}) - chroma_t'({1'b0, CHROMA_MID});
  endfunction

  // coefficient times centered chroma, fits in a sum_t
  function automatic sum_t coef_mul(input chroma_t d, input logic signed [COEF_W-1:0] k);
    logic signed [CHR_W+COEF_W-1:0] p;
    p = d * k;
    return p[SUM_W-1:0];
  endfunction

  // luma placed at q16
  function automatic sum_t luma_q16(input pix_t y);
    return sum_t'({{(SUM_W-PIX_W-FRAC_W){1'b0}}, y, {FRAC_W{1'b0}}});
  endfunction

  // (c * 220) >> 8
  function automatic pix_t scale(input pix_t c);
    logic [2*PIX_W-1:0] p;
    p = {{PIX_W{1'b0}}, c} * SCALE_MUL;
    return p[2*PIX_W-1:PIX_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/yrgb_stream_if.sv =====
// stream interfaces for yuyv macropixel words and rgb pixel-pair words
`default_nettype none

interface yrgb_yuyv_if;
  logic valid;
  logic ready;
  logic [yrgb_pkg::PIX_W-1:0] luma_first;
  logic [yrgb_pkg::PIX_W-1:0] chroma_blue;
  logic [yrgb_pkg::PIX_W-1:0] luma_second;
  logic [yrgb_pkg::PIX_W-1:0] chroma_red;
  logic frame_end_in;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  frame_end_in, input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                frame_end_in, output ready);
endinterface

interface yrgb_rgb_if;
  logic valid;
  logic ready;
  logic [yrgb_pkg::PIX_W-1:0] red_first;
  logic [yrgb_pkg::PIX_W-1:0] green_first;
  logic [yrgb_pkg::PIX_W-1:0] blue_first;
  logic [yrgb_pkg::PIX_W-1:0] red_second;
  logic [yrgb_pkg::PIX_W-1:0] green_second;
  logic [yrgb_pkg::PIX_W-1:0] blue_second;
  logic frame_end_out;

  modport source (output valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, frame_end_out, input ready);
  modport sink (input valid, red_first, green_first, blue_first, red_second,
                green_second, blue_second, frame_end_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/yrgb_clamp.sv =====
// truncate a signed q16 channel sum to its integer part and clamp to 0..255
`default_nettype none

module yrgb_clamp (
  input  wire yrgb_pkg::sum_t sum,
  output yrgb_pkg::pix_t      level
);

  localparam int unsigned HI = yrgb_pkg::FRAC_W + yrgb_pkg::PIX_W;

  always_comb begin
    priority if (sum[yrgb_pkg::SUM_W-1]) begin
      level = '0;
    end else if (|sum[yrgb_pkg::SUM_W-2:HI]) begin
      level = yrgb_pkg::PIX_MAX;
    end else begin
      level = sum[HI-1:yrgb_pkg::FRAC_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/yuyv_to_rgb_scaled_top.sv =====
// top level: yuyv macropixel to two scaled rgb888 pixels, five-stage pipeline
`default_nettype none

// Converts one YUYV macropixel word (Y0, U, Y1, V) into one word carrying two
// RGB pixels that share U and V. Each channel is Y plus q16 chroma terms,
// truncated to its integer part, clamped to 0..255 and scaled by 220/256, so
// every output channel lies in 0..219. frame_end rides along unchanged.
// Throughput is one word per clock while the sink takes words; a word
// accepted into the stage 1 register moves on through stages 2, 3 and 4 into
// the stage 5 output register. The pipeline is:
//   stage 1  register inputs, center U and V around 128
//   stage 2  four coefficient multipliers (one per chroma term)
//   stage 3  combine the two green terms
//   stage 4  add luma in q16 for both pixels, truncate and clamp
//   stage 5  scale by 220/256, output register
// Each stage holds a valid bit and advances when it is empty or the stage
// after it advances, so bubbles are squeezed out and a stalled sink never
// loses or repeats a word.

`include "assert_macros.svh"

module yuyv_to_rgb_scaled_top (
  input wire clk,
  input wire rst,
  yrgb_yuyv_if.sink  yuyv,
  yrgb_rgb_if.source rgb
);

  localparam int unsigned NS = yrgb_pkg::STAGES;

  // stage valid bits and advance enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || rgb.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign yuyv.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= yuyv.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: capture and center chroma
  yrgb_pkg::pix_t    y0_s1, y1_s1;
  yrgb_pkg::chroma_t du_s1, dv_s1;
  logic              fe_s1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y0_s1 <= yuyv.luma_first;
      y1_s1 <= yuyv.luma_second;
      du_s1 <= yrgb_pkg::center(yuyv.chroma_blue);
      dv_s1 <= yrgb_pkg::center(yuyv.chroma_red);
      fe_s1 <= yuyv.frame_end_in;
    end
  end

  // stage 2: chroma products
  yrgb_pkg::pix_t y0_s2, y1_s2;
  yrgb_pkg::sum_t rv_s2, gv_s2, gu_s2, bu_s2;
  logic           fe_s2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y0_s2 <= y0_s1;
      y1_s2 <= y1_s1;
      rv_s2 <= yrgb_pkg::coef_mul(dv_s1, yrgb_pkg::COEF_R_V);
      gv_s2 <= yrgb_pkg::coef_mul(dv_s1, yrgb_pkg::COEF_G_V);
      gu_s2 <= yrgb_pkg::coef_mul(du_s1, yrgb_pkg::COEF_G_U);
      bu_s2 <= yrgb_pkg::coef_mul(du_s1, yrgb_pkg::COEF_B_U);
      fe_s2 <= fe_s1;
    end
  end

  // stage 3: green takes both chroma terms
  yrgb_pkg::pix_t y0_s3, y1_s3;
  yrgb_pkg::sum_t rv_s3, g_s3, bu_s3;
  logic           fe_s3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y0_s3 <= y0_s2;
      y1_s3 <= y1_s2;
      rv_s3 <= rv_s2;
      g_s3  <= gv_s2 + gu_s2;
      bu_s3 <= bu_s2;
      fe_s3 <= fe_s2;
    end
  end

  // stage 4: add luma and clamp, six channels
  yrgb_pkg::sum_t base0, base1;
  yrgb_pkg::sum_t sr0, sg0, sb0, sr1, sg1, sb1;
  yrgb_pkg::pix_t cr0, cg0, cb0, cr1, cg1, cb1;

  assign base0 = yrgb_pkg::luma_q16(y0_s3);
  assign base1 = yrgb_pkg::luma_q16(y1_s3);
  assign sr0 = base0 + rv_s3;
  assign sg0 = base0 - g_s3;
  assign sb0 = base0 + bu_s3;
  assign sr1 = base1 + rv_s3;
  assign sg1 = base1 - g_s3;
  assign sb1 = base1 + bu_s3;

  yrgb_clamp u_clamp_r0 (.sum(sr0), .level(cr0));
  yrgb_clamp u_clamp_g0 (.sum(sg0), .level(cg0));
  yrgb_clamp u_clamp_b0 (.sum(sb0), .level(cb0));
  yrgb_clamp u_clamp_r1 (.sum(sr1), .level(cr1));
  yrgb_clamp u_clamp_g1 (.sum(sg1), .level(cg1));
  yrgb_clamp u_clamp_b1 (.sum(sb1), .level(cb1));

  yrgb_pkg::pix_t r0_s4, g0_s4, b0_s4, r1_s4, g1_s4, b1_s4;
  logic           fe_s4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r0_s4 <= cr0;
      g0_s4 <= cg0;
      b0_s4 <= cb0;
      r1_s4 <= cr1;
      g1_s4 <= cg1;
      b1_s4 <= cb1;
      fe_s4 <= fe_s3;
    end
  end

  // stage 5: scale into the output register
  yrgb_pkg::pix_t r0_s5, g0_s5, b0_s5, r1_s5, g1_s5, b1_s5;
  logic           fe_s5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r0_s5 <= yrgb_pkg::scale(r0_s4);
      g0_s5 <= yrgb_pkg::scale(g0_s4);
      b0_s5 <= yrgb_pkg::scale(b0_s4);
      r1_s5 <= yrgb_pkg::scale(r1_s4);
      g1_s5 <= yrgb_pkg::scale(g1_s4);
      b1_s5 <= yrgb_pkg::scale(b1_s4);
      fe_s5 <= fe_s4;
    end
  end

  assign rgb.valid         = v[NS-1];
  assign rgb.red_first     = r0_s5;
  assign rgb.green_first   = g0_s5;
  assign rgb.blue_first    = b0_s5;
  assign rgb.red_second    = r1_s5;
  assign rgb.green_second  = g1_s5;
  assign rgb.blue_second   = b1_s5;
  assign rgb.frame_end_out = fe_s5;

  // an empty output register means the whole pipe can take a word
  `YRGB_ASSERT_IMP(a_ready_when_out_empty, clk, rst, !v[NS-1], yuyv.ready)
  // a full middle stage (stage 3) that cannot advance keeps its word
  `YRGB_ASSERT_NEXT(a_mid_stage_holds, clk, rst, v[2] && !en[2], v[2])
  // scaled channels never exceed 219
  `YRGB_ASSERT_IMP(a_out_range, clk, rst, rgb.valid, (rgb.red_first <= yrgb_pkg::OUT_MAX) && (rgb.green_first <= yrgb_pkg::OUT_MAX) && (rgb.blue_first <= yrgb_pkg::OUT_MAX) && (rgb.red_second <= yrgb_pkg::OUT_MAX) && (rgb.green_second <= yrgb_pkg::OUT_MAX) && (rgb.blue_second <= yrgb_pkg::OUT_MAX))

endmodule

`default_nettype wire

// ===== dv/yuyv_to_rgb_scaled_top_tb.sv =====
// testbench for the yuyv to scaled rgb converter: random stall stimulus and pixel-pair scoreboard
module yuyv_to_rgb_scaled_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef yrgb_pkg::pix_t pix_t;

  // q16 coefficients of the conversion, rounded to nearest
  localparam longint KQ_RED_V   = 89831;
  localparam longint KQ_GREEN_V = 45744;
  localparam longint KQ_GREEN_U = 22127;
  localparam longint KQ_BLUE_U  = 113538;
  localparam int     MID_LEVEL  = 128;
  localparam int     OUT_SCALE  = 220;

  localparam int RANDOM_WORDS = 700;
  localparam int BLOCK_WORDS  = 50;
  // the slowest run stays under this limit, even with every gap and stall long
  localparam int CYCLE_LIMIT  = 400000;
  // five pipeline stages, plus margin for a stray word
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    pix_t luma_first;
    pix_t chroma_blue;
    pix_t luma_second;
    pix_t chroma_red;
    logic frame_end;
  } macropixel_t;

  typedef struct {
    pix_t red_first;
    pix_t green_first;
    pix_t blue_first;
    pix_t red_second;
    pix_t green_second;
    pix_t blue_second;
    logic frame_end;
  } pixel_pair_t;

  // holds the pixel pairs still owed by the block, oldest first
  class rgb_pair_scoreboard;
    pixel_pair_t expected_pairs[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // truncate the q16 sum, clamp to 0..255, then scale by 220/256
    static function pix_t scaled_channel(input longint q16_sum);
      longint whole;
      if (q16_sum <= 0) return '0;
      whole = q16_sum >>> 16;
      if (whole > 255) whole = 255;
      return pix_t'((whole * OUT_SCALE) >> 8);
    endfunction

    static function void rgb_from_luma(input pix_t luma, input longint du, input longint dv,
                                       output pix_t red, output pix_t green,
                                       output pix_t blue);
      longint base;
      base  = longint'(luma) << 16;
      red   = scaled_channel(base + KQ_RED_V * dv);
      green = scaled_channel(base - KQ_GREEN_V * dv - KQ_GREEN_U * du);
      blue  = scaled_channel(base + KQ_BLUE_U * du);
    endfunction

    static function pixel_pair_t predict_pair(input macropixel_t mp);
      pixel_pair_t pp;
      longint      du;
      longint      dv;
      du = longint'(mp.chroma_blue) - MID_LEVEL;
      dv = longint'(mp.chroma_red) - MID_LEVEL;
      rgb_from_luma(mp.luma_first, du, dv, pp.red_first, pp.green_first, pp.blue_first);
      rgb_from_luma(mp.luma_second, du, dv, pp.red_second, pp.green_second, pp.blue_second);
      pp.frame_end = mp.frame_end;
      return pp;
    endfunction

    function void note_macropixel(input macropixel_t mp);
      expected_pairs.push_back(predict_pair(mp));
    endfunction

    function void compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_pixel_pair(input pixel_pair_t got);
      pixel_pair_t want;
      if (expected_pairs.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected rgb word, expected none, actual r0=%0d g0=%0d b0=%0d",
                 $time, got.red_first, got.green_first, got.blue_first);
        return;
      end
      want = expected_pairs.pop_front();
      compare_field("red_first", want.red_first, got.red_first);
      compare_field("green_first", want.green_first, got.green_first);
      compare_field("blue_first", want.blue_first, got.blue_first);
      compare_field("red_second", want.red_second, got.red_second);
      compare_field("green_second", want.green_second, got.green_second);
      compare_field("blue_second", want.blue_second, got.blue_second);
      compare_field("frame_end_out", 8'(want.frame_end), 8'(got.frame_end));
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  // set per block of random words: neither side idles while it is high
  logic steady = 1'b0;
  int   cycle_count = 0;

  rgb_pair_scoreboard sb;

  yrgb_yuyv_if yuyv_ch ();
  yrgb_rgb_if  rgb_ch ();

  yuyv_to_rgb_scaled_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .yuyv (yuyv_ch),
    .rgb  (rgb_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // safety net against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rgb words outstanding", cycle_count,
               sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // byte that favors the corners of the conversion (clamp and saturate)
  function automatic pix_t corner_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd129;
      5: return 8'd254;
      6: return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // sampled before the edge updates, so each check sees what the edge accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (yuyv_ch.valid === 1'b1 && yuyv_ch.ready === 1'b1)
        sb.note_macropixel('{yuyv_ch.luma_first, yuyv_ch.chroma_blue, yuyv_ch.luma_second,
                             yuyv_ch.chroma_red, yuyv_ch.frame_end_in});
      if (rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1)
        sb.check_pixel_pair('{rgb_ch.red_first, rgb_ch.green_first, rgb_ch.blue_first,
                              rgb_ch.red_second, rgb_ch.green_second, rgb_ch.blue_second,
                              rgb_ch.frame_end_out});
    end
  end

  // hold one word on the input until the block takes it, after a random gap
  task automatic send_macropixel(input macropixel_t mp);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      yuyv_ch.valid <= 1'b0;
      @(posedge clk);
    end
    yuyv_ch.valid        <= 1'b1;
    yuyv_ch.luma_first   <= mp.luma_first;
    yuyv_ch.chroma_blue  <= mp.chroma_blue;
    yuyv_ch.luma_second  <= mp.luma_second;
    yuyv_ch.chroma_red   <= mp.chroma_red;
    yuyv_ch.frame_end_in <= mp.frame_end;
    do @(posedge clk); while (yuyv_ch.ready !== 1'b1);
  endtask

  task automatic send_directed();
    macropixel_t list[$];
    // neutral chroma at both luma extremes and at mid luma
    list.push_back('{8'd0, 8'd128, 8'd255, 8'd128, 1'b0});
    list.push_back('{8'd128, 8'd128, 8'd128, 8'd128, 1'b0});
    // every byte at zero, then every byte at full scale
    list.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    list.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    // chroma corners, with mixed and with equal luma
    list.push_back('{8'd255, 8'd0, 8'd0, 8'd255, 1'b0});
    list.push_back('{8'd0, 8'd255, 8'd255, 8'd0, 1'b1});
    list.push_back('{8'd255, 8'd0, 8'd255, 8'd0, 1'b0});
    list.push_back('{8'd0, 8'd255, 8'd0, 8'd255, 1'b0});
    // red and blue sums just below zero clamp to zero
    list.push_back('{8'd0, 8'd127, 8'd0, 8'd127, 1'b0});
    list.push_back('{8'd1, 8'd126, 8'd1, 8'd126, 1'b0});
    // sums just above 255 saturate
    list.push_back('{8'd255, 8'd129, 8'd254, 8'd129, 1'b0});
    list.push_back('{8'd254, 8'd130, 8'd253, 8'd127, 1'b1});
    // studio range luma, common video levels
    list.push_back('{8'd16, 8'd128, 8'd235, 8'd128, 1'b0});
    list.push_back('{8'd16, 8'd16, 8'd235, 8'd240, 1'b0});
    list.push_back('{8'd81, 8'd90, 8'd145, 8'd240, 1'b0});
    list.push_back('{8'd170, 8'd166, 8'd41, 8'd16, 1'b1});
    // alternating bit patterns
    list.push_back('{8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0});
    list.push_back('{8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1});
    foreach (list[i]) send_macropixel(list[i]);
  endtask

  task automatic send_random();
    macropixel_t mp;
    bit          corner_block;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // each block picks its own idling and value flavor
      if (n % BLOCK_WORDS == 0) begin
        steady       <= ($urandom_range(0, 3) == 0);
        corner_block = ($urandom_range(0, 4) == 0);
      end
      if (corner_block) begin
        mp.luma_first  = corner_byte();
        mp.chroma_blue = corner_byte();
        mp.luma_second = corner_byte();
        mp.chroma_red  = corner_byte();
      end else begin
        mp.luma_first  = pix_t'($urandom_range(0, 255));
        mp.chroma_blue = pix_t'($urandom_range(0, 255));
        mp.luma_second = pix_t'($urandom_range(0, 255));
        mp.chroma_red  = pix_t'($urandom_range(0, 255));
      end
      // short frames, a few words each
      mp.frame_end = ($urandom_range(0, 15) == 0);
      send_macropixel(mp);
    end
  endtask

  // output side: runs of ready broken by random stalls
  initial begin
    int run;
    int stall;
    rgb_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      run = steady ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (run) begin
        rgb_ch.ready <= 1'b1;
        @(posedge clk);
      end
      stall = steady ? 0 : pick_gap();
      repeat (stall) begin
        rgb_ch.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // main sequence: reset, directed words, random words, drain
  initial begin
    sb = new();
    yuyv_ch.valid        <= 1'b0;
    yuyv_ch.luma_first   <= '0;
    yuyv_ch.chroma_blue  <= '0;
    yuyv_ch.luma_second  <= '0;
    yuyv_ch.chroma_red   <= '0;
    yuyv_ch.frame_end_in <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_directed();
    send_random();
    yuyv_ch.valid <= 1'b0;

    // every owed word must come out, then nothing more
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/yrgb_pkg.sv
rtl/core/yrgb_stream_if.sv
rtl/core/yrgb_clamp.sv
rtl/core/yuyv_to_rgb_scaled_top.sv
dv/yuyv_to_rgb_scaled_top_tb.sv
